// File: hdl/hamc_pkg.sv
`default_nettype none
package hamc_pkg;

   // Operation codes carried on req_tuser
   localparam logic OP_ENCODE = 1'b0;
   localparam logic OP_DECODE = 1'b1;

   // Result status codes
   localparam logic [1:0] STAT_CLEAN  = 2'd0;
   localparam logic [1:0] STAT_FIXED  = 2'd1;
   localparam logic [1:0] STAT_DOUBLE = 2'd2;

   localparam int DATA_BITS = 11;
   localparam int CODE_BITS = 16;

   // Block positions of the data bits, least significant data bit first
   localparam logic [3:0] DATA_POS [DATA_BITS] = '{
      4'd3, 4'd5, 4'd6, 4'd7, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15
   };

   // Front stage: raw block (scattered data or received word)
   typedef struct packed {
      logic        op;
      logic [15:0] blk;
   } front_type;

   // Check stage: raw block with its syndrome and overall parity
   typedef struct packed {
      logic        op;
      logic [15:0] blk;
      logic [3:0]  syn;
      logic        par;
   } check_type;

   // Finished result
   typedef struct packed {
      logic [3:0]  flip_position;
      logic [1:0]  status;
      logic [10:0] data_out;
      logic [15:0] block_out;
   } result_type;

   // Place data bits at their block positions
   function automatic logic [15:0] scatter_data(input logic [10:0] d);
      logic [15:0] b;
      b = '0;
      for (int k = 0; k < DATA_BITS; k++) begin
         b[DATA_POS[k]] = d[k];
      end
      return b;
   endfunction

   // Gather data bits back from their block positions
   function automatic logic [10:0] extract_data(input logic [15:0] b);
      logic [10:0] d;
      d = '0;
      for (int k = 0; k < DATA_BITS; k++) begin
         d[k] = b[DATA_POS[k]];
      end
      return d;
   endfunction

   // XOR of the indices of all set bits in positions 1..15
   function automatic logic [3:0] syndrome_of(input logic [15:0] b);
      logic [3:0] s;
      s = '0;
      for (int i = 1; i < CODE_BITS; i++) begin
         if (b[i]) begin
            s = s ^ 4'(i);
         end
      end
      return s;
   endfunction

endpackage
`default_nettype wire

// File: hdl/hamming_16_11_secded_codec_core.sv
// An accepted request beat passes the front, check and fix registers on its way to its response beat.
// Throughput: one beat per cycle; the three register stages (scatter/select,
// syndrome and parity, correct and extract) all advance together and hold
// while the response register waits on rsp_tready.
// Reset: synchronous, active high; clears the stage valid bits only.
`default_nettype none
module hamming_16_11_secded_codec_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // [10:0] data_word, [26:11] code_word, zero pad
   input  wire logic        req_tuser,  // [0] op
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata   // [15:0] block_out, [26:16] data_out,
                                        // [28:27] status, [32:29] flip_position, zero pad
);
   import hamc_pkg::*;

   logic       advance;
   logic       front_valid;
   logic       check_valid;
   logic       fix_valid;
   front_type  front;
   check_type  check;
   result_type result;

   // Move the whole pipe unless a finished beat is stuck at the output
   assign advance    = !fix_valid || rsp_tready;
   assign req_tready = advance;

   hamc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_tvalid),
      .op        (req_tuser),
      .data_word (req_tdata[10:0]),
      .code_word (req_tdata[26:11]),
      .valid_ff  (front_valid),
      .front_ff  (front)
   );

   hamc_check u_check (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (front_valid),
      .front    (front),
      .valid_ff (check_valid),
      .check_ff (check)
   );

   hamc_fix u_fix (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (check_valid),
      .check     (check),
      .valid_ff  (fix_valid),
      .result_ff (result)
   );

   assign rsp_tvalid = fix_valid;
   assign rsp_tdata  = {7'd0, result.flip_position, result.status,
                        result.data_out, result.block_out};

   // Status code 3 is never produced
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[28:27] != 2'd3))
      else $error("invalid status code");

   // A flip position is reported only with a corrected single error
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[28:27] != STAT_FIXED)) |-> (rsp_tdata[32:29] == 4'd0))
      else $error("flip position without correction");

   // The pipe is empty at the first edge after reset is released
   assert property (@(posedge clock)
      ($past(reset) && !reset) |-> !rsp_tvalid)
      else $error("response valid after reset");

   // An empty output stage never blocks the input
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

endmodule
`default_nettype wire

// File: hdl/hamc_front.sv
`default_nettype none
module hamc_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  wire logic                in_valid,
   input  wire logic                op,
   input  wire logic [10:0]         data_word,
   input  wire logic [15:0]         code_word,
   output logic                     valid_ff,
   output hamc_pkg::front_type      front_ff
);
   import hamc_pkg::*;

   logic      valid_in;
   front_type front_in;

   // Select the raw block: scatter data on encode, take the word on decode
   always_comb begin
      valid_in     = in_valid;
      front_in.op  = op;
      if (op == OP_ENCODE) begin
         front_in.blk = scatter_data(data_word);
      end else begin
         front_in.blk = code_word;
      end
   end

   // Hold valid under reset, advance with the pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         front_ff <= front_in;
      end
   end

endmodule
`default_nettype wire

// File: hdl/hamc_check.sv
`default_nettype none
module hamc_check (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  wire logic                in_valid,
   input  wire hamc_pkg::front_type front,
   output logic                     valid_ff,
   output hamc_pkg::check_type      check_ff
);
   import hamc_pkg::*;

   logic      valid_in;
   check_type check_in;

   // Form syndrome and overall parity of the raw block
   always_comb begin
      valid_in     = in_valid;
      check_in.op  = front.op;
      check_in.blk = front.blk;
      check_in.syn = syndrome_of(front.blk);
      check_in.par = ^front.blk;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         check_ff <= check_in;
      end
   end

endmodule
`default_nettype wire

// File: hdl/hamc_fix.sv
`default_nettype none
module hamc_fix (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  wire logic                in_valid,
   input  wire hamc_pkg::check_type check,
   output logic                     valid_ff,
   output hamc_pkg::result_type     result_ff
);
   import hamc_pkg::*;

   logic        valid_in;
   result_type  result_in;
   logic [15:0] blk;

   always_comb begin
      valid_in = in_valid;
      blk      = check.blk;
      result_in.status        = STAT_CLEAN;
      result_in.flip_position = '0;
      result_in.data_out      = '0;
      if (check.op == OP_ENCODE) begin
         // Drop in the Hamming parity bits, then overall even parity
         blk[1] = check.syn[0];
         blk[2] = check.syn[1];
         blk[4] = check.syn[2];
         blk[8] = check.syn[3];
         blk[0] = check.par ^ (^check.syn);
      end else begin
         // Odd parity means one flip at the syndrome position
         if (check.par) begin
            blk                     = check.blk ^ (16'd1 << check.syn);
            result_in.status        = STAT_FIXED;
            result_in.flip_position = check.syn;
         end else if (check.syn != 4'd0) begin
            result_in.status = STAT_DOUBLE;
         end
         result_in.data_out = extract_data(blk);
      end
      result_in.block_out = blk;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

endmodule
`default_nettype wire
